// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Holds screen geometry, character codes, command and result records.
// No dependencies.
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Field widths
   localparam int MODE_W = 2;
   localparam int DATA_W = 16;
   localparam int IDX_W  = 11;

   // Internal widths
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CUR_W  = $clog2(CELLS + COLUMNS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   // Reciprocal of COLUMNS for splitting a cell index into row and column
   localparam int RSH     = IDX_W + $clog2(COLUMNS);
   localparam int RECIP   = ((1 << RSH) + COLUMNS - 1) / COLUMNS;
   localparam int RECIP_W = IDX_W + 2;
   localparam int PROD_W  = IDX_W + RECIP_W;

   // Tab expansion
   localparam int TAB_CELLS = 4;
   localparam int TAB_W     = $clog2(TAB_CELLS);

   // Cell constants
   localparam logic [DATA_W-1:0] BLANK_CELL   = 16'h0720;
   localparam logic [DATA_W-1:0] DEFAULT_ATTR = 16'h0700;
   localparam logic [7:0]        CHAR_MASK    = 8'hFF;
   localparam logic [7:0]        SPACE_CHAR   = 8'h20;

   // Control characters
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT  = 2'd0,
      MODE_READ = 2'd1,
      MODE_SET  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_CHAR,
      OP_BACKSPACE,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_READ,
      OP_SET,
      OP_NOP
   } op_type;

   // Classified request handed from the front to the back
   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] cell_word;
      logic [IDX_W-1:0]  idx;
   } cmd_type;

   // Finished result
   typedef struct packed {
      logic [IDX_W-1:0]  cursor_pos;
      logic [DATA_W-1:0] cell_data;
   } rsp_type;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tcw_front.sv =====
// Front end of the text console writer: accepts requests, classifies them
// and holds them in a two-entry command queue. Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [DATA_W-1:0] req_char_code,
   input  logic [IDX_W-1:0]  req_cell_index,
   input  logic              clearing,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output cmd_type           cmd
);

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   cmd_type           new_cmd;
   logic [DATA_W-1:0] code;
   logic [IDX_W-1:0]  idx_clamped;
   logic              accept;

   // Apply default attribute and clamp the index
   always_comb begin
      code = req_char_code;
      if (req_char_code[DATA_W-1:8] == 8'd0) begin
         code = req_char_code | DEFAULT_ATTR;
      end
      idx_clamped = req_cell_index;
      if (32'(req_cell_index) >= CELLS) begin
         idx_clamped = IDX_W'(CELLS - 1);
      end
   end

   // Classify the request
   always_comb begin
      new_cmd.cell_word = code;
      new_cmd.idx       = idx_clamped;
      new_cmd.op        = OP_NOP;
      unique case (mode_type'(req_mode))
         MODE_PUT: begin
            if ((code[7:0] & CHAR_MASK) == CH_BACKSPACE) begin
               new_cmd.op = OP_BACKSPACE;
            end else if (code[7:0] == CH_NEWLINE) begin
               new_cmd.op = OP_NEWLINE;
            end else if (code[7:0] == CH_RETURN) begin
               new_cmd.op = OP_RETURN;
            end else if (code[7:0] == CH_TAB) begin
               new_cmd.op = OP_TAB;
            end else begin
               new_cmd.op = OP_CHAR;
            end
         end
         MODE_READ: new_cmd.op = OP_READ;
         MODE_SET:  new_cmd.op = OP_SET;
         MODE_NONE: new_cmd.op = OP_NOP;
      endcase
   end

   assign full      = (count_ff == 2'd2) || clearing;
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (cmd_pop && cmd_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      unique case ({accept, cmd_pop && cmd_valid})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued commands
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// Back end of the text console writer: sequencer that owns the screen RAM
// and the cursor, runs the clearing pass, scrolls and emits results.
// Depends on tcw_pkg and tcw_ram.
module tcw_back import tcw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd,
   output logic    clearing,
   output logic    rsp_push,
   input  logic    rsp_full,
   output rsp_type rsp
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_READ,
      S_DIV1,
      S_DIV2,
      S_CHECK,
      S_SCROLL,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CUR_W-1:0]  cur_ff, cur_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TAB_W-1:0]  tab_ff, tab_in;
   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CUR_W-1:0]  rowbase_ff, rowbase_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   logic [CNT_W:0]          scr_src;
   logic [PROD_W-RSH-1:0]   quot;
   logic                    tab_more;

   tcw_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign scr_src  = {1'b0, cnt_ff} + (CNT_W + 1)'(COLUMNS);
   assign quot     = prod_ff[PROD_W-1:RSH];
   assign tab_more = (cmd_ff.op == OP_TAB) && (tab_ff != '0);
   assign clearing = (state_ff == S_CLEAR);
   assign rsp.cursor_pos = cur_ff[IDX_W-1:0];
   assign rsp.cell_data  = data_ff;

   // Sequence one command
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      col_in     = col_ff;
      cnt_in     = cnt_ff;
      tab_in     = tab_ff;
      cmd_in     = cmd_ff;
      data_in    = data_ff;
      prod_in    = prod_ff;
      rowbase_in = rowbase_ff;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_wdata  = '0;
      ram_raddr  = '0;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;

      unique case (state_ff)
         // Blank the screen after reset, one cell a cycle
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[ADDR_W-1:0];
            ram_wdata = BLANK_CELL;
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Take the next request
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               data_in  = '0;
               tab_in   = TAB_W'(TAB_CELLS - 1);
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (cmd_ff.op)
               OP_CHAR, OP_TAB: begin
                  ram_we    = 1'b1;
                  ram_waddr = cur_ff[ADDR_W-1:0];
                  ram_wdata = (cmd_ff.op == OP_TAB) ? BLANK_CELL : cmd_ff.cell_word;
                  cur_in    = cur_ff + 1'b1;
                  col_in    = (32'(col_ff) == COLUMNS - 1) ? '0 : col_ff + 1'b1;
                  state_in  = S_CHECK;
               end
               OP_BACKSPACE: begin
                  if (cur_ff != '0) begin
                     ram_we    = 1'b1;
                     ram_waddr = ADDR_W'(cur_ff - 1'b1);
                     ram_wdata = {cmd_ff.cell_word[DATA_W-1:8], SPACE_CHAR};
                     cur_in    = cur_ff - 1'b1;
                     col_in    = (col_ff == '0) ? COL_W'(COLUMNS - 1) : col_ff - 1'b1;
                  end
                  state_in = S_DONE;
               end
               OP_NEWLINE: begin
                  cur_in   = cur_ff - CUR_W'(col_ff) + CUR_W'(COLUMNS);
                  col_in   = '0;
                  state_in = S_CHECK;
               end
               OP_RETURN: begin
                  cur_in   = cur_ff - CUR_W'(col_ff);
                  col_in   = '0;
                  state_in = S_DONE;
               end
               OP_READ: begin
                  ram_raddr = cmd_ff.idx[ADDR_W-1:0];
                  state_in  = S_READ;
               end
               OP_SET: begin
                  cur_in   = CUR_W'(cmd_ff.idx);
                  prod_in  = PROD_W'(cmd_ff.idx) * PROD_W'(RECIP);
                  state_in = S_DIV1;
               end
               OP_NOP: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // Capture the cell read
         S_READ: begin
            data_in  = ram_rdata;
            state_in = S_DONE;
         end

         // Split the new cursor into row start and column
         S_DIV1: begin
            rowbase_in = CUR_W'(32'(quot) * COLUMNS);
            state_in   = S_DIV2;
         end

         S_DIV2: begin
            col_in   = COL_W'(cur_ff - rowbase_ff);
            state_in = S_DONE;
         end

         // Scroll when the cursor runs off the end, else repeat a tab cell or finish
         S_CHECK: begin
            if (32'(cur_ff) >= CELLS) begin
               cnt_in   = '0;
               state_in = S_SCROLL;
            end else if (tab_more) begin
               tab_in   = tab_ff - 1'b1;
               state_in = S_EXEC;
            end else begin
               state_in = S_DONE;
            end
         end

         // Read one row ahead, write back one cell behind, blank the last row
         S_SCROLL: begin
            if (32'(scr_src) < CELLS) begin
               ram_raddr = scr_src[ADDR_W-1:0];
            end
            if (cnt_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = ADDR_W'(cnt_ff - 1'b1);
               ram_wdata = (32'(cnt_ff) <= CELLS - COLUMNS) ? ram_rdata : BLANK_CELL;
            end
            if (cnt_ff == CNT_W'(CELLS)) begin
               cnt_in = '0;
               cur_in = cur_ff - CUR_W'(COLUMNS);
               if (tab_more) begin
                  tab_in   = tab_ff - 1'b1;
                  state_in = S_EXEC;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Hand the result to the output queue
         S_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cur_ff   <= '0;
         col_ff   <= '0;
         cnt_ff   <= '0;
         tab_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         col_ff   <= col_in;
         cnt_ff   <= cnt_in;
         tab_ff   <= tab_in;
      end
      cmd_ff     <= cmd_in;
      data_ff    <= data_in;
      prod_ff    <= prod_in;
      rowbase_ff <= rowbase_in;
   end

endmodule

// ===== hw/rtl/tcw_out_queue.sv =====
// Two-entry result queue between the back end and the result ports.
// Depends on tcw_pkg.
module tcw_out_queue import tcw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    rsp_push,
   output logic    rsp_full,
   input  rsp_type rsp_in_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_out_data
);

   rsp_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign rsp_full     = (count_ff == 2'd2);
   assign empty        = (count_ff == 2'd0);
   assign do_push      = rsp_push && !rsp_full;
   assign do_pop       = pop && !empty;
   assign rsp_out_data = queue_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued results
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= rsp_in_data;
      end
   end

endmodule

// ===== hw/rtl/text_console_writer_core.sv =====
// Top level of the text console writer: front end, back end, result queue.
// Depends on tcw_pkg, tcw_front, tcw_back, tcw_out_queue.
//
// Text-mode screen writer with a COLUMNS x ROWS store of 16-bit cells and a
// cursor. Requests are pushed while full is low and results popped while
// empty is low; each request gives exactly one result. After reset a
// clearing pass blanks the store, one cell a cycle, with full held high.
// The back-end sequencer takes one request at a time from the command
// queue and takes the next only after it has handed the result to the
// result queue. The result can be popped in the cycle after the sequencer
// hands it to the result queue. Each scroll is a sweep that copies every
// cell one row up through the screen RAM and blanks the last row.
module text_console_writer_core import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [DATA_W-1:0] req_char_code,
   input  logic [IDX_W-1:0]  req_cell_index,
   output logic              empty,
   input  logic              pop,
   output logic [IDX_W-1:0]  rsp_cursor_pos,
   output logic [DATA_W-1:0] rsp_cell_data
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    clearing;
   logic    rsp_push;
   logic    rsp_full;
   rsp_type rsp_back;
   rsp_type rsp_head;

   // Accept and classify requests
   tcw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_mode       (req_mode),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .clearing       (clearing),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .cmd            (cmd)
   );

   // Carry out commands against the screen store
   tcw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .clearing  (clearing),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full),
      .rsp       (rsp_back)
   );

   // Hold finished results until popped
   tcw_out_queue u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .rsp_push     (rsp_push),
      .rsp_full     (rsp_full),
      .rsp_in_data  (rsp_back),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_data (rsp_head)
   );

   assign rsp_cursor_pos = rsp_head.cursor_pos;
   assign rsp_cell_data  = rsp_head.cell_data;

endmodule

// ===== dv/tcw_checker.sv =====
// Checker for the text console writer: predicts each result and compares it.
// Depends on tcw_pkg; watches the request and result queue ports of the core.
`timescale 1ns / 1ps

module tcw_checker import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [DATA_W-1:0] req_char_code,
   input  logic [IDX_W-1:0]  req_cell_index,
   input  logic              empty,
   input  logic              pop,
   input  logic [IDX_W-1:0]  rsp_cursor_pos,
   input  logic [DATA_W-1:0] rsp_cell_data,
   output int                mismatches,
   output int                outstanding
);

   // Shadow screen and cursor
   logic [DATA_W-1:0] screen [CELLS];
   int unsigned       cursor;
   rsp_type           pending_rsp_q[$];

   function automatic void clear_screen();
      for (int k = 0; k < CELLS; k++) screen[k] = BLANK_CELL;
      cursor = 0;
   endfunction

   // Shift rows up once the cursor runs past the last cell
   function automatic void scroll_if_past_end();
      if (cursor >= CELLS) begin
         for (int k = 0; k < CELLS - COLUMNS; k++) screen[k] = screen[k + COLUMNS];
         for (int k = CELLS - COLUMNS; k < CELLS; k++) screen[k] = BLANK_CELL;
         cursor = cursor - COLUMNS;
      end
   endfunction

   function automatic void store_at_cursor(logic [DATA_W-1:0] value);
      if (cursor < CELLS) screen[cursor] = value;
      cursor++;
   endfunction

   function automatic int unsigned clamp_cell(logic [IDX_W-1:0] idx);
      return (idx >= CELLS) ? CELLS - 1 : int'(idx);
   endfunction

   // Interpret one character in put mode
   function automatic void put_char(logic [DATA_W-1:0] code);
      if (code[15:8] == 8'h00) code = code | DEFAULT_ATTR;
      case (code[7:0])
         CH_BACKSPACE: begin
            if (cursor > 0) begin
               cursor--;
               screen[cursor] = {code[15:8], SPACE_CHAR};
            end
         end
         CH_NEWLINE: begin
            cursor = cursor + COLUMNS;
            cursor = cursor - cursor % COLUMNS;
         end
         CH_RETURN: cursor = cursor - cursor % COLUMNS;
         CH_TAB: begin
            for (int k = 0; k < TAB_CELLS; k++) begin
               store_at_cursor(BLANK_CELL);
               scroll_if_past_end();
            end
         end
         default: store_at_cursor(code);
      endcase
      scroll_if_past_end();
   endfunction

   // Work out the result of one request
   function automatic rsp_type predict_console(logic [MODE_W-1:0] mode,
                                               logic [DATA_W-1:0] code,
                                               logic [IDX_W-1:0]  idx);
      rsp_type r;
      r.cell_data = '0;
      case (mode_type'(mode))
         MODE_PUT:  put_char(code);
         MODE_READ: r.cell_data = screen[clamp_cell(idx)];
         MODE_SET:  cursor = clamp_cell(idx);
         default:   ;
      endcase
      r.cursor_pos = cursor[IDX_W-1:0];
      return r;
   endfunction

   // Queue predictions on accepted requests, compare accepted results
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_screen();
         pending_rsp_q.delete();
         mismatches = 0;
      end else begin
         if (push && !full)
            pending_rsp_q.push_back(predict_console(req_mode, req_char_code, req_cell_index));
         if (pop && !empty) begin
            if (pending_rsp_q.size() == 0) begin
               $error("result with no request waiting: cursor_pos %0d cell_data %h",
                      rsp_cursor_pos, rsp_cell_data);
               mismatches++;
            end else begin
               want = pending_rsp_q.pop_front();
               if (rsp_cursor_pos !== want.cursor_pos) begin
                  $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, rsp_cursor_pos);
                  mismatches++;
               end
               if (rsp_cell_data !== want.cell_data) begin
                  $error("cell_data: expected %h, got %h", want.cell_data, rsp_cell_data);
                  mismatches++;
               end
            end
         end
      end
      outstanding = pending_rsp_q.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the text console writer testbench: clock, reset, stimulus, verdict.
// Depends on tcw_pkg, text_console_writer_core and tcw_checker.
`timescale 1ns / 1ps

module testbench;
   import tcw_pkg::*;

   localparam int RANDOM_REQUESTS = 1400;
   localparam int STALL_LIMIT     = 12000;
   localparam int DRAIN_CYCLES    = 30;

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   logic [MODE_W-1:0] req_mode;
   logic [DATA_W-1:0] req_char_code;
   logic [IDX_W-1:0]  req_cell_index;
   logic              empty;
   logic              pop;
   logic [IDX_W-1:0]  rsp_cursor_pos;
   logic [DATA_W-1:0] rsp_cell_data;
   int                mismatches;
   int                outstanding;
   int                requests_sent;
   int                results_taken;
   bit                sender_no_idle;
   bit                receiver_no_idle;

   text_console_writer_core uut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_mode       (req_mode),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .empty          (empty),
      .pop            (pop),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data)
   );

   tcw_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_mode       (req_mode),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .empty          (empty),
      .pop            (pop),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(mode_type m, logic [DATA_W-1:0] code, logic [IDX_W-1:0] idx);
      int gap;
      if (requests_sent % 40 == 0) sender_no_idle = ($urandom_range(0, 3) == 0);
      gap = sender_no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         @(negedge clock);
         push = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      push           = 1'b1;
      req_mode       = m;
      req_char_code  = code;
      req_cell_index = idx;
      @(posedge clock);
      while (full) @(posedge clock);
      requests_sent++;
   endtask

   task automatic put_char(logic [DATA_W-1:0] code);
      send_request(MODE_PUT, code, IDX_W'($urandom_range(0, 2047)));
   endtask

   // Random character: mostly printable text, some control codes
   function automatic logic [DATA_W-1:0] random_char();
      logic [7:0] attr;
      logic [7:0] ch;
      int         pick;
      attr = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 6)       ch = CH_BACKSPACE;
      else if (pick < 10) ch = CH_NEWLINE;
      else if (pick < 14) ch = CH_RETURN;
      else if (pick < 18) ch = CH_TAB;
      else if (pick < 80) ch = 8'($urandom_range(32, 126));
      else                ch = 8'($urandom);
      return {attr, ch};
   endfunction

   // Mixed single request of any mode
   task automatic send_noise();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      put_char(DATA_W'($urandom));
      else if (pick < 65) send_request(MODE_READ, DATA_W'($urandom), IDX_W'($urandom_range(0, 2047)));
      else if (pick < 90) send_request(MODE_SET, DATA_W'($urandom), IDX_W'($urandom_range(0, 2047)));
      else                send_request(MODE_NONE, DATA_W'($urandom), IDX_W'($urandom));
   endtask

   // Line of text, optionally placed near the bottom, ended by newline
   task automatic send_text_line(bit near_bottom);
      int len;
      if (near_bottom)
         send_request(MODE_SET, DATA_W'($urandom), IDX_W'($urandom_range(CELLS - 2 * COLUMNS, 2047)));
      else if ($urandom_range(0, 2) == 0)
         send_request(MODE_SET, DATA_W'($urandom), IDX_W'($urandom_range(0, CELLS - 1)));
      len = $urandom_range(3, 20);
      for (int k = 0; k < len; k++) put_char(random_char());
      if ($urandom_range(0, 1) == 0)
         send_request(MODE_READ, DATA_W'($urandom), IDX_W'($urandom_range(0, CELLS - 1)));
      put_char({8'($urandom_range(0, 1) ? $urandom : 0), CH_NEWLINE});
   endtask

   // Stimulus: reset, directed cases, random traffic, drain, verdict
   initial begin
      int pick;
      bit paused_once;
      reset          = 1'b1;
      push           = 1'b0;
      pop            = 1'b0;
      req_mode       = '0;
      req_char_code  = '0;
      req_cell_index = '0;
      requests_sent  = 0;
      paused_once    = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: default attribute, controls, clamping, scrolls, unused mode
      put_char(16'h0041);
      put_char(16'h1F42);
      send_request(MODE_READ, 16'h0000, 11'd0);
      put_char({8'h00, CH_TAB});
      put_char({8'h3C, CH_BACKSPACE});
      put_char({8'h00, CH_RETURN});
      put_char({8'h00, CH_BACKSPACE});
      put_char({8'h00, CH_NEWLINE});
      put_char(16'hFFFF);
      send_request(MODE_READ, 16'hFFFF, 11'd80);
      send_request(MODE_SET, 16'h0000, 11'd2047);
      send_request(MODE_READ, 16'h0000, 11'd2047);
      put_char(16'h0058);
      send_request(MODE_SET, 16'h0000, 11'(CELLS - 1));
      put_char({8'h00, CH_NEWLINE});
      send_request(MODE_SET, 16'h0000, 11'(CELLS - 2));
      put_char({8'h5A, CH_TAB});
      send_request(MODE_NONE, 16'hFFFF, 11'd2047);
      send_request(MODE_SET, 16'h0000, 11'd0);
      put_char(16'h0000);
      send_request(MODE_READ, 16'h0000, 11'd0);
      send_request(MODE_SET, 16'h0000, 11'(CELLS - COLUMNS + 5));
      put_char({8'h00, CH_RETURN});
      put_char({8'hAB, CH_NEWLINE});
      send_request(MODE_SET, 16'h0000, 11'(CELLS));

      // Random: mostly text lines, some near the bottom, the rest noise
      while (requests_sent < RANDOM_REQUESTS) begin
         if (!paused_once && requests_sent >= RANDOM_REQUESTS / 2) begin
            // hold until every result has come back
            @(negedge clock);
            push = 1'b0;
            wait (outstanding == 0);
            paused_once = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55)      send_text_line(1'b0);
         else if (pick < 70) send_text_line(1'b1);
         else                send_noise();
      end
      @(negedge clock);
      push = 1'b0;

      // Drain, then watch for stray results
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Receiver: random gaps, one long hold-off to back the core up
   initial begin
      int gap;
      results_taken = 0;
      forever begin
         if (results_taken % 40 == 0) receiver_no_idle = ($urandom_range(0, 3) == 0);
         gap = receiver_no_idle ? 0 : $urandom_range(0, 9);
         if (results_taken == 300) gap = 400;
         if (gap > 0) begin
            @(negedge clock);
            pop = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         pop = 1'b1;
         @(posedge clock);
         while (empty || reset) @(posedge clock);
         results_taken++;
      end
   end

   // Watchdog: end the run if nothing moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/tcw_out_queue.sv
hw/rtl/text_console_writer_core.sv
dv/tcw_checker.sv
dv/testbench.sv
